@@ hdl/websocket_frame_deframer_top_assert.svh @@
// Assertion macros for the websocket frame deframer checker.
`ifndef WEBSOCKET_FRAME_DEFRAMER_TOP_ASSERT_SVH
`define WEBSOCKET_FRAME_DEFRAMER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WSFD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define WSFD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/wsfd_pkg.sv @@
package wsfd_pkg;

  localparam int LenW = 64;
  localparam int CntW = 32;
  localparam int CfgW = 32;
  localparam int AvW  = (CntW > CfgW) ? CntW : CfgW;
  localparam int CmpW = (LenW > AvW) ? LenW : AvW;

  localparam logic [CfgW-1:0] MaxMsgReset = CfgW'(100 * 1024 * 1024);
  localparam logic [15:0]     NoCloseCode = 16'd1005;
  localparam logic [6:0]      CtrlMax     = 7'h7d;
  localparam logic [7:0]      RsvMask     = 8'h70;

  typedef logic [3:0] opcode_t;

  localparam opcode_t OpCont  = 4'h0;
  localparam opcode_t OpText  = 4'h1;
  localparam opcode_t OpBin   = 4'h2;
  localparam opcode_t OpClose = 4'h8;
  localparam opcode_t OpPing  = 4'h9;
  localparam opcode_t OpPong  = 4'ha;

  typedef enum logic [1:0] {
    KindNone = 2'd0,
    KindData = 2'd1,
    KindCtrl = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    ErrNone       = 4'd0,
    ErrOpcode     = 4'd1,
    ErrRsv        = 4'd2,
    ErrFragCtrl   = 4'd3,
    ErrCont       = 4'd4,
    ErrCtrlLen    = 4'd5,
    ErrMasked     = 4'd6,
    ErrTooLong    = 4'd7,
    ErrAfterClose = 4'd8
  } err_e;

endpackage

@@ hdl/websocket_frame_deframer_top.sv @@
// Receive-side websocket frame parser: one stream byte in, one result word out, one word per
// clock sustained while out_ready_i is high. Each byte is captured in an input register and
// resolved against the frame state in a single pass into the result register, from which the
// result word is presented. in_ready_o drops only while the result register holds a word
// that is not taken and the input register is also full. The first error latches and every
// later word repeats its code until reset. Write max_message_bytes only while no word is in
// flight.
module websocket_frame_deframer_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [wsfd_pkg::CfgW-1:0] cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [7:0]                rx_byte_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [1:0]                kind_o,
  output logic [7:0]                payload_byte_o,
  output logic [3:0]                frame_opcode_o,
  output logic                      frame_end_o,
  output logic                      message_end_o,
  output logic [15:0]               close_code_o,
  output logic [3:0]                error_o
);
  import wsfd_pkg::*;

  typedef enum logic [1:0] {
    PhFirst  = 2'd0,
    PhSecond = 2'd1,
    PhExtLen = 2'd2,
    PhData   = 2'd3
  } phase_e;

  localparam int FinBit = 7;

  logic [CfgW-1:0] max_q;
  logic            in_vld_q;
  logic [7:0]      in_byte_q;
  logic            out_vld_q;
  logic [1:0]      out_kind_q;
  logic [7:0]      out_byte_q;
  opcode_t         out_op_q;
  logic            out_fend_q;
  logic            out_mend_q;
  logic [15:0]     out_code_q;
  err_e            out_err_q;

  phase_e          phase_q, phase_d;
  logic [LenW-1:0] rem_q, rem_d;
  logic [3:0]      lbl_q, lbl_d;
  logic            ctrl_q, ctrl_d;
  logic            final_q, final_d;
  opcode_t         cur_op_q, cur_op_d;
  opcode_t         msg_op_q, msg_op_d;
  logic            expect_q, expect_d;
  logic [CntW-1:0] msg_len_q, msg_len_d;
  logic [6:0]      cnt_q, cnt_d;
  logic [15:0]     code_reg_q, code_reg_d;
  logic            close_seen_q, close_seen_d;
  err_e            err_q, err_d;

  logic            adv;
  logic            fire;

  kind_e           res_kind;
  logic [7:0]      res_byte;
  opcode_t         res_op;
  logic            res_fend;
  logic            res_mend;
  logic [15:0]     res_code;
  err_e            new_err;

  logic [7:0]      b;
  opcode_t         op;
  logic            op_valid;
  logic [LenW-1:0] rem_len;
  logic            len_known;
  logic            finish;
  logic [3:0]      lbl_dec;
  logic [AvW-1:0]  max_w;
  logic [AvW-1:0]  len_w;
  logic [AvW-1:0]  avail_w;
  logic [CmpW-1:0] avail;

  assign adv         = !out_vld_q || out_ready_i;
  assign in_ready_o  = !in_vld_q || adv;
  assign fire        = in_vld_q && adv;

  assign b        = in_byte_q;
  assign op       = b[3:0];
  assign op_valid = (op == OpCont) || (op == OpText) || (op == OpBin) ||
                    (op == OpClose) || (op == OpPing) || (op == OpPong);

  assign max_w   = AvW'(max_q);
  assign len_w   = AvW'(msg_len_q);
  assign avail_w = (max_w > len_w) ? (max_w - len_w) : '0;
  assign avail   = CmpW'(avail_w);

  always_comb begin
    phase_d      = phase_q;
    rem_d        = rem_q;
    lbl_d        = lbl_q;
    ctrl_d       = ctrl_q;
    final_d      = final_q;
    cur_op_d     = cur_op_q;
    msg_op_d     = msg_op_q;
    expect_d     = expect_q;
    msg_len_d    = msg_len_q;
    cnt_d        = cnt_q;
    code_reg_d   = code_reg_q;
    close_seen_d = close_seen_q;
    err_d        = err_q;
    res_kind     = KindNone;
    res_byte     = 8'h00;
    res_op       = OpCont;
    res_fend     = 1'b0;
    res_mend     = 1'b0;
    res_code     = 16'h0000;
    new_err      = ErrNone;
    rem_len      = rem_q;
    len_known    = 1'b0;
    finish       = 1'b0;
    lbl_dec      = lbl_q;
    if (err_q == ErrNone) begin
      unique case (phase_q)
        PhFirst: begin
          if (close_seen_q) begin
            new_err = ErrAfterClose;
          end else if (!op_valid) begin
            new_err = ErrOpcode;
          end else if ((b & RsvMask) != 8'h00) begin
            new_err = ErrRsv;
          end else if (op[3]) begin
            if (!b[FinBit]) new_err = ErrFragCtrl;
          end else if (expect_q) begin
            if (op == OpCont) new_err = ErrCont;
          end else if (op != OpCont) begin
            new_err = ErrCont;
          end
          if (new_err == ErrNone) begin
            final_d  = b[FinBit];
            ctrl_d   = op[3];
            cur_op_d = op;
            if (op[3]) begin
              cnt_d      = '0;
              code_reg_d = 16'h0000;
            end else if (expect_q) begin
              expect_d = 1'b0;
              msg_op_d = op;
            end
            phase_d = PhSecond;
          end
        end
        PhSecond: begin
          if (ctrl_q && (b[6:0] > CtrlMax)) begin
            new_err = ErrCtrlLen;
          end else if (b[7]) begin
            new_err = ErrMasked;
          end else if (b[6:0] >= 7'h7e) begin
            lbl_d   = b[0] ? 4'd8 : 4'd2;
            rem_d   = '0;
            phase_d = PhExtLen;
          end else begin
            rem_len   = LenW'(b[6:0]);
            len_known = 1'b1;
          end
        end
        PhExtLen: begin
          rem_len   = {rem_q[LenW-9:0], b};
          rem_d     = rem_len;
          lbl_dec   = (lbl_q != 4'd0) ? (lbl_q - 4'd1) : 4'd0;
          lbl_d     = lbl_dec;
          len_known = (lbl_dec == 4'd0);
        end
        PhData: begin
          res_byte = b;
          if (ctrl_q) begin
            res_kind = KindCtrl;
            res_op   = cur_op_q;
            if (cnt_q == 7'd0) begin
              code_reg_d = {b, 8'h00};
            end else if (cnt_q == 7'd1) begin
              code_reg_d = {code_reg_q[15:8], b};
            end
            if (cnt_q != 7'h7f) cnt_d = cnt_q + 7'd1;
          end else begin
            res_kind = KindData;
            res_op   = msg_op_q;
            if (msg_len_q != {CntW{1'b1}}) msg_len_d = msg_len_q + CntW'(1);
          end
          rem_d  = (rem_q != '0) ? (rem_q - LenW'(1)) : rem_q;
          finish = (rem_d == '0);
        end
        default: ;
      endcase
      if (len_known) begin
        phase_d = PhData;
        rem_d   = rem_len;
        if (!ctrl_q && (CmpW'(rem_len) > avail)) begin
          new_err = ErrTooLong;
        end else if (rem_len == '0) begin
          finish = 1'b1;
        end
      end
      if (finish) begin
        phase_d  = PhFirst;
        res_fend = 1'b1;
        res_op   = ctrl_q ? cur_op_q : msg_op_q;
        if (ctrl_q) begin
          if (cur_op_q == OpClose) begin
            close_seen_d = 1'b1;
            res_code     = (cnt_d >= 7'd2) ? code_reg_d : NoCloseCode;
          end
        end else if (final_q) begin
          res_mend  = 1'b1;
          expect_d  = 1'b1;
          msg_len_d = '0;
        end
      end
      if (new_err != ErrNone) begin
        err_d    = new_err;
        res_kind = KindNone;
        res_byte = 8'h00;
        res_op   = OpCont;
        res_fend = 1'b0;
        res_mend = 1'b0;
        res_code = 16'h0000;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q        <= MaxMsgReset;
      in_vld_q     <= 1'b0;
      in_byte_q    <= 8'h00;
      out_vld_q    <= 1'b0;
      out_kind_q   <= KindNone;
      out_byte_q   <= 8'h00;
      out_op_q     <= OpCont;
      out_fend_q   <= 1'b0;
      out_mend_q   <= 1'b0;
      out_code_q   <= 16'h0000;
      out_err_q    <= ErrNone;
      phase_q      <= PhFirst;
      rem_q        <= '0;
      lbl_q        <= 4'd0;
      ctrl_q       <= 1'b0;
      final_q      <= 1'b0;
      cur_op_q     <= OpCont;
      msg_op_q     <= OpCont;
      expect_q     <= 1'b1;
      msg_len_q    <= '0;
      cnt_q        <= '0;
      code_reg_q   <= 16'h0000;
      close_seen_q <= 1'b0;
      err_q        <= ErrNone;
    end else begin
      if (cfg_we_i) max_q <= cfg_wdata_i;
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
        if (in_valid_i) in_byte_q <= rx_byte_i;
      end
      if (adv) out_vld_q <= in_vld_q;
      if (fire) begin
        out_kind_q   <= res_kind;
        out_byte_q   <= res_byte;
        out_op_q     <= res_op;
        out_fend_q   <= res_fend;
        out_mend_q   <= res_mend;
        out_code_q   <= res_code;
        out_err_q    <= err_d;
        phase_q      <= phase_d;
        rem_q        <= rem_d;
        lbl_q        <= lbl_d;
        ctrl_q       <= ctrl_d;
        final_q      <= final_d;
        cur_op_q     <= cur_op_d;
        msg_op_q     <= msg_op_d;
        expect_q     <= expect_d;
        msg_len_q    <= msg_len_d;
        cnt_q        <= cnt_d;
        code_reg_q   <= code_reg_d;
        close_seen_q <= close_seen_d;
        err_q        <= err_d;
      end
    end
  end

  assign out_valid_o    = out_vld_q;
  assign kind_o         = out_kind_q;
  assign payload_byte_o = out_byte_q;
  assign frame_opcode_o = out_op_q;
  assign frame_end_o    = out_fend_q;
  assign message_end_o  = out_mend_q;
  assign close_code_o   = out_code_q;
  assign error_o        = out_err_q;

endmodule

@@ hdl/wsfd_checker.sv @@
`include "websocket_frame_deframer_top_assert.svh"

module wsfd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  kind_o,
  input logic [7:0]  payload_byte_o,
  input logic [3:0]  frame_opcode_o,
  input logic        frame_end_o,
  input logic        message_end_o,
  input logic [15:0] close_code_o,
  input logic [3:0]  error_o
);
  import wsfd_pkg::*;

  `WSFD_ASSERT_IMPL(a_err_zeros, clk_i, rst_ni,
    out_valid_o && (error_o != ErrNone),
    (kind_o == KindNone) && (payload_byte_o == 8'h00) && (frame_opcode_o == OpCont) &&
    !frame_end_o && !message_end_o && (close_code_o == 16'h0000),
    "error word carries nonzero fields")

  `WSFD_ASSERT_IMPL(a_hdr_no_byte, clk_i, rst_ni,
    out_valid_o && (kind_o == KindNone),
    (payload_byte_o == 8'h00),
    "header word carries a payload byte")

  `WSFD_ASSERT_IMPL(a_msg_end, clk_i, rst_ni,
    out_valid_o && message_end_o,
    frame_end_o && (kind_o != KindCtrl) && (close_code_o == 16'h0000),
    "message end outside a data frame end")

  `WSFD_ASSERT_IMPL(a_close_code, clk_i, rst_ni,
    out_valid_o && (close_code_o != 16'h0000),
    frame_end_o && (frame_opcode_o == OpClose),
    "close code outside a close frame end")

  `WSFD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni,
    out_valid_o && !out_ready_i,
    out_valid_o && $stable(kind_o) && $stable(payload_byte_o) && $stable(error_o) &&
    $stable(frame_end_o) && $stable(close_code_o),
    "stalled result word changed")

endmodule

bind websocket_frame_deframer_top wsfd_checker u_wsfd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .kind_o         (kind_o),
  .payload_byte_o (payload_byte_o),
  .frame_opcode_o (frame_opcode_o),
  .frame_end_o    (frame_end_o),
  .message_end_o  (message_end_o),
  .close_code_o   (close_code_o),
  .error_o        (error_o)
);
